// ===== design/lru_key_value_cache_core_defines.svh =====
// assertion macros shared by the cache core
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LKVC_ASSERT_NOW(label, cond, concl) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (concl)) \
		else $error("lkvc same-cycle check failed");

// next-cycle implication, checked outside reset
`define LKVC_ASSERT_NEXT(label, cond, concl) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (concl)) \
		else $error("lkvc next-cycle check failed");

`endif

// ===== design/lkvc_pkg.sv =====
// package: beat types, controller types and constants of the cache core
`default_nettype none
package lkvc_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int KEY_BITS_DEF    = 64;
	localparam int VALUE_BITS_DEF  = 32;

	localparam int          CAP_BITS  = 5;
	localparam logic [4:0]  CAP_RESET = 5'd16;
	localparam logic        REG_CAPACITY = 1'b0;

	localparam logic        OP_GET = 1'b0;
	localparam logic        OP_PUT = 1'b1;

	localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

	typedef struct packed {
		logic               operation;
		logic [63:0]        lookup_key;
		logic signed [31:0] write_value;
	} req_beat_t;

	typedef struct packed {
		logic               key_found;
		logic signed [31:0] read_value;
		logic               entry_evicted;
	} rsp_beat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic capture;
		logic execute;
		logic emit;
	} dp_cmd_t;

endpackage
`default_nettype wire

// ===== design/lkvc_ctrl.sv =====
// controller: sequences capture, match/update and result beats
`default_nettype none
module lkvc_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output lkvc_pkg::dp_cmd_t    cmd
);
	import lkvc_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   can_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign can_emit  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_MATCH;
				end
			end
			ST_MATCH: begin
				cmd.execute = 1'b1;
				state_d     = ST_RESP;
			end
			ST_RESP: begin
				if (can_emit) begin
					cmd.emit  = 1'b1;
					req_stall = 1'b0;
					if (req_valid) begin
						cmd.capture = 1'b1;
						state_d     = ST_MATCH;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== design/lkvc_datapath.sv =====
// datapath: key match lanes, recency ranks, value memory and result register
`default_nettype none
module lkvc_datapath #(
	parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF,
	parameter int KEY_BITS    = lkvc_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS  = lkvc_pkg::VALUE_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lkvc_pkg::dp_cmd_t    cmd,
	input  wire lkvc_pkg::req_beat_t  req,
	input  wire logic [4:0]           capacity,
	output lkvc_pkg::rsp_beat_t       rsp
);
	import lkvc_pkg::*;

	localparam int IW   = $clog2(MAX_ENTRIES);
	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int CMPW = (CW > CAP_BITS) ? CW : CAP_BITS;

	// captured request
	logic                  op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] wval_q;
	logic signed [63:0]    wval_wide;

	// entry state
	logic [KEY_BITS-1:0]   keys_q  [MAX_ENTRIES];
	logic                  valid_q [MAX_ENTRIES];
	logic [IW-1:0]         rank_q  [MAX_ENTRIES];
	logic [CW-1:0]         count_q;
	logic [VALUE_BITS-1:0] val_mem [MAX_ENTRIES];

	logic                  valid_d [MAX_ENTRIES];
	logic [IW-1:0]         rank_d  [MAX_ENTRIES];
	logic [CW-1:0]         count_d;

	// match results
	logic [MAX_ENTRIES-1:0] match;
	logic [MAX_ENTRIES-1:0] victim;
	logic [MAX_ENTRIES-1:0] free_lane;
	logic                   hit;
	logic [IW-1:0]          hit_idx;
	logic [IW-1:0]          hit_rank;
	logic [IW-1:0]          slot_idx;
	logic [IW-1:0]          oldest;
	logic [CMPW-1:0]        eff_cap;
	logic                   full;
	logic                   is_put;
	logic                   do_evict;
	logic                   do_insert;
	logic                   mem_wr;
	logic [IW-1:0]          mem_waddr;

	// carried to the result cycle
	logic                   found_q;
	logic                   evicted_q;
	logic                   get_q;
	logic [VALUE_BITS-1:0]  rdata_q;
	logic signed [VALUE_BITS-1:0] rdata_s;
	logic signed [63:0]     rdata_wide;
	rsp_beat_t              rsp_q;

	assign wval_wide = 64'(req.write_value);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= req.operation;
			key_q  <= req.lookup_key[KEY_BITS-1:0];
			wval_q <= wval_wide[VALUE_BITS-1:0];
		end
	end

	always_comb begin
		hit_idx  = '0;
		slot_idx = '0;
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			match[i]     = valid_q[i] && (keys_q[i] == key_q);
			if (match[i]) begin
				hit_idx = IW'(i);
			end
		end
		hit = |match;

		eff_cap = CMPW'(capacity);
		if (capacity == '0) begin
			eff_cap = CMPW'(1);
		end else if (CMPW'(capacity) > CMPW'(MAX_ENTRIES)) begin
			eff_cap = CMPW'(MAX_ENTRIES);
		end
		full      = CMPW'(count_q) >= eff_cap;
		oldest    = IW'(count_q - CW'(1));
		hit_rank  = rank_q[hit_idx];
		is_put    = (op_q == OP_PUT);
		do_evict  = is_put && !hit && full;
		do_insert = is_put && !hit;

		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			victim[i]    = valid_q[i] && (rank_q[i] == oldest);
			free_lane[i] = !valid_q[i] || (do_evict && victim[i]);
			if (free_lane[i]) begin
				slot_idx = IW'(i);
			end
		end

		count_d = count_q;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			valid_d[i] = valid_q[i];
			rank_d[i]  = rank_q[i];
			if (hit) begin
				if (IW'(i) == hit_idx) begin
					rank_d[i] = '0;
				end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
					rank_d[i] = rank_q[i] + IW'(1);
				end
			end else if (do_insert) begin
				if (IW'(i) == slot_idx) begin
					valid_d[i] = 1'b1;
					rank_d[i]  = '0;
				end else if (valid_q[i]) begin
					rank_d[i] = rank_q[i] + IW'(1);
				end
			end
		end
		if (do_insert && !do_evict) begin
			count_d = count_q + CW'(1);
		end

		mem_wr    = is_put;
		mem_waddr = hit ? hit_idx : slot_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				rank_q[i]  <= '0;
			end
			count_q <= '0;
		end else if (cmd.execute) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				valid_q[i] <= valid_d[i];
				rank_q[i]  <= rank_d[i];
			end
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute && do_insert) begin
			keys_q[slot_idx] <= key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			if (mem_wr) begin
				val_mem[mem_waddr] <= wval_q;
			end
			rdata_q   <= val_mem[hit_idx];
			found_q   <= hit;
			evicted_q <= do_evict;
			get_q     <= !is_put;
		end
	end

	assign rdata_s    = rdata_q;
	assign rdata_wide = 64'(rdata_s);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.key_found     <= found_q;
			rsp_q.entry_evicted <= evicted_q;
			if (!get_q) begin
				rsp_q.read_value <= '0;
			end else if (found_q) begin
				rsp_q.read_value <= rdata_wide[31:0];
			end else begin
				rsp_q.read_value <= MISS_VALUE;
			end
		end
	end

	assign rsp = rsp_q;

endmodule
`default_nettype wire

// ===== design/lru_key_value_cache_core.sv =====
// top level: fully associative key-value cache with least-recently-used replacement
`default_nettype none
// Each request beat (get or put) produces exactly one response beat. A match step
// compares the key against every entry in parallel, updates the recency ranks and reads
// the value memory (registered read port); a result step then loads the response
// register. A new request is taken in the same cycle its predecessor's result enters the
// response register, so its capture overlaps that result step; a stalled response side
// holds off new requests. No clearing pass follows reset; the cache is usable at once.
// capacity_in_use sits at byte address 0; 0 acts as 1, values above MAX_ENTRIES clamp to
// MAX_ENTRIES. Write it only while no item is in flight.
module lru_key_value_cache_core #(
	parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF,
	parameter int KEY_BITS    = lkvc_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS  = lkvc_pkg::VALUE_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire lkvc_pkg::req_beat_t  req,
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	output lkvc_pkg::rsp_beat_t       rsp,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [2:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import lkvc_pkg::*;

	`include "lru_key_value_cache_core_defines.svh"

	logic [4:0] capacity_q;
	logic       cfg_wr;
	dp_cmd_t    cmd;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_wr) begin
			capacity_q <= pwdata[4:0];
		end
	end

	assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity_q) : '0;

	lkvc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	lkvc_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.KEY_BITS    (KEY_BITS),
		.VALUE_BITS  (VALUE_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (req),
		.capacity (capacity_q),
		.rsp      (rsp)
	);

	`LKVC_ASSERT_NEXT(a_accept_then_busy, req_valid && !req_stall, req_stall)
	`LKVC_ASSERT_NOW(a_evict_is_put, rsp_valid && rsp.entry_evicted, rsp.read_value == 32'sd0)
	`LKVC_ASSERT_NOW(a_evict_only_miss, rsp_valid && rsp.entry_evicted, !rsp.key_found)

endmodule
`default_nettype wire

// ===== dv/lru_key_value_cache_core_tb.sv =====
// testbench for the lru key-value cache core: directed table, then random get/put phases
`default_nettype none
module lru_key_value_cache_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lkvc_pkg::*;

	localparam int         DEPTH         = MAX_ENTRIES_DEF;
	localparam int         CYCLE_LIMIT   = 200000;
	localparam int         PHASE_ITEMS   = 55;
	localparam int         QUIET_PHASE   = 4;
	localparam logic [2:0] CAP_ADDR      = {REG_CAPACITY, 2'b00};
	localparam logic [2:0] UNUSED_ADDR   = {~REG_CAPACITY, 2'b00};
	localparam logic [63:0] KEY_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic        op;
		logic [2:0]  addr;
		logic [63:0] key;
		logic [31:0] data;
		bit          typed;
		rsp_beat_t   want;
	} script_row_t;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_beat_t   req;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_beat_t   rsp;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// cache image used for prediction
	logic [63:0] slot_key   [DEPTH];
	logic [31:0] slot_value [DEPTH];
	bit          slot_live  [DEPTH];
	int          slot_age   [DEPTH];
	int          live_count;
	logic [4:0]  capacity_reg;

	rsp_beat_t   cache_replies [$];
	int          error_count = 0;
	int          cycle_count = 0;
	bit          quiet_mode  = 1'b0;

	logic [4:0]  phase_caps [8] = '{5'd31, 5'd1, 5'd0, 5'd4, 5'd16, 5'd2, 5'd9, 5'd3};

	script_row_t directed_rows [22] = '{
		'{ROW_ITEM, OP_GET, 3'd0, 64'd0, 32'd0, 1'b1, '{1'b0, MISS_VALUE, 1'b0}},
		'{ROW_ITEM, OP_PUT, 3'd0, 64'd0, 32'h7FFF_FFFF, 1'b1, '{1'b0, 32'd0, 1'b0}},
		'{ROW_ITEM, OP_GET, 3'd0, 64'd0, 32'd0, 1'b1, '{1'b1, 32'h7FFF_FFFF, 1'b0}},
		'{ROW_ITEM, OP_PUT, 3'd0, KEY_ONES, 32'h8000_0000, 1'b1, '{1'b0, 32'd0, 1'b0}},
		'{ROW_ITEM, OP_GET, 3'd0, KEY_ONES, 32'h1234_5678, 1'b1, '{1'b1, 32'h8000_0000, 1'b0}},
		'{ROW_ITEM, OP_PUT, 3'd0, 64'd0, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'd0, 1'b0}},
		'{ROW_ITEM, OP_GET, 3'd0, 64'd0, 32'd0, 1'b1, '{1'b1, 32'hFFFF_FFFF, 1'b0}},
		'{ROW_ITEM, OP_GET, 3'd0, 64'd1, 32'd0, 1'b1, '{1'b0, MISS_VALUE, 1'b0}},
		// write to an unused index must leave the capacity alone
		'{ROW_REG, OP_GET, UNUSED_ADDR, 64'd0, 32'd1, 1'b0, '0},
		'{ROW_ITEM, OP_PUT, 3'd0, 64'd5, 32'd5, 1'b1, '{1'b0, 32'd0, 1'b0}},
		// capacity below the fill
		'{ROW_REG, OP_GET, CAP_ADDR, 64'd0, 32'd2, 1'b0, '0},
		'{ROW_ITEM, OP_PUT, 3'd0, 64'd6, 32'd6, 1'b0, '0},
		'{ROW_ITEM, OP_GET, 3'd0, KEY_ONES, 32'd0, 1'b1, '{1'b0, MISS_VALUE, 1'b0}},
		'{ROW_ITEM, OP_GET, 3'd0, 64'd0, 32'd0, 1'b0, '0},
		'{ROW_ITEM, OP_PUT, 3'd0, 64'd7, 32'd7, 1'b0, '0},
		'{ROW_ITEM, OP_GET, 3'd0, 64'd5, 32'd0, 1'b1, '{1'b0, MISS_VALUE, 1'b0}},
		// zero capacity acts as one
		'{ROW_REG, OP_GET, CAP_ADDR, 64'd0, 32'd0, 1'b0, '0},
		'{ROW_ITEM, OP_PUT, 3'd0, 64'd8, 32'd8, 1'b0, '0},
		'{ROW_ITEM, OP_GET, 3'd0, 64'd6, 32'd0, 1'b0, '0},
		// oversized capacity clamps
		'{ROW_REG, OP_GET, CAP_ADDR, 64'd0, 32'd31, 1'b0, '0},
		'{ROW_ITEM, OP_PUT, 3'd0, 64'd9, 32'd9, 1'b0, '0},
		'{ROW_ITEM, OP_GET, 3'd0, 64'd8, 32'd0, 1'b0, '0}
	};

	lru_key_value_cache_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #1 clk = ~clk;

	function automatic rsp_beat_t cache_access(req_beat_t b);
		rsp_beat_t r;
		int hit;
		int victim;
		int free_slot;
		int cap;
		int aged;
		r = '0;
		hit = -1;
		victim = -1;
		free_slot = -1;
		for (int i = 0; i < DEPTH; i++)
			if (hit < 0 && slot_live[i] && slot_key[i] == b.lookup_key) hit = i;
		if (hit >= 0) begin
			r.key_found = 1'b1;
			if (b.operation == OP_GET) r.read_value = slot_value[hit];
			else slot_value[hit] = b.write_value;
			aged = slot_age[hit];
			for (int i = 0; i < DEPTH; i++)
				if (slot_live[i] && slot_age[i] < aged) slot_age[i]++;
			slot_age[hit] = 0;
		end else if (b.operation == OP_GET) begin
			r.read_value = MISS_VALUE;
		end else begin
			cap = int'(capacity_reg);
			if (cap == 0) cap = 1;
			if (cap > DEPTH) cap = DEPTH;
			if (live_count >= cap) begin
				for (int i = 0; i < DEPTH; i++)
					if (slot_live[i] && (victim < 0 || slot_age[i] > slot_age[victim]))
						victim = i;
				if (victim >= 0) begin
					slot_live[victim] = 1'b0;
					slot_age[victim] = 0;
					live_count--;
					r.entry_evicted = 1'b1;
				end
			end
			for (int i = 0; i < DEPTH; i++)
				if (free_slot < 0 && !slot_live[i]) free_slot = i;
			if (free_slot >= 0) begin
				for (int i = 0; i < DEPTH; i++)
					if (slot_live[i]) slot_age[i]++;
				slot_key[free_slot] = b.lookup_key;
				slot_value[free_slot] = b.write_value;
				slot_live[free_slot] = 1'b1;
				slot_age[free_slot] = 0;
				live_count++;
			end
		end
		return r;
	endfunction

	task automatic send_item(input req_beat_t beat, input bit typed, input rsp_beat_t want);
		rsp_beat_t got;
		while (!quiet_mode && $urandom_range(0, 99) < 33) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req <= beat;
		do @(posedge clk); while (req_stall);
		got = cache_access(beat);
		cache_replies.push_back(typed ? want : got);
	endtask

	task automatic settle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (cache_replies.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr[2] == REG_CAPACITY) capacity_reg = data[4:0];
		// read back the capacity
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= CAP_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[4:0] !== capacity_reg) begin
			$error("capacity_in_use: expected %0d, got %0d", capacity_reg, prdata[4:0]);
			error_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	always @(negedge clk) rsp_stall <= !quiet_mode && ($urandom_range(0, 99) < 33);

	always @(posedge clk) begin : reply_check
		rsp_beat_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (cache_replies.size() == 0) begin
				$error("response beat with nothing outstanding");
				error_count++;
			end else begin
				want = cache_replies.pop_front();
				if (rsp.key_found !== want.key_found) begin
					$error("key_found: expected %0d, got %0d", want.key_found, rsp.key_found);
					error_count++;
				end
				if (rsp.read_value !== want.read_value) begin
					$error("read_value: expected %0d, got %0d", want.read_value, rsp.read_value);
					error_count++;
				end
				if (rsp.entry_evicted !== want.entry_evicted) begin
					$error("entry_evicted: expected %0d, got %0d",
						want.entry_evicted, rsp.entry_evicted);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("lru_key_value_cache_core verification failed");
			$finish;
		end
	end

	initial begin
		req_beat_t   beat;
		logic [63:0] key_pool [$];
		logic [4:0]  cap;
		logic [31:0] wv;
		int          pool_size;
		int          eff;
		int          pick;
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		for (int i = 0; i < DEPTH; i++) begin
			slot_key[i] = '0;
			slot_value[i] = '0;
			slot_live[i] = 1'b0;
			slot_age[i] = 0;
		end
		live_count = 0;
		capacity_reg = CAP_RESET;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[n]) begin
			if (directed_rows[n].kind == ROW_REG) begin
				settle();
				write_reg(directed_rows[n].addr, directed_rows[n].data);
			end else begin
				beat.operation = directed_rows[n].op;
				beat.lookup_key = directed_rows[n].key;
				beat.write_value = directed_rows[n].data;
				send_item(beat, directed_rows[n].typed, directed_rows[n].want);
			end
		end

		for (int p = 0; p < 8; p++) begin
			settle();
			cap = (p == 7) ? 5'($urandom_range(0, 31)) : phase_caps[p];
			write_reg(CAP_ADDR, {27'd0, cap});
			quiet_mode = (p == QUIET_PHASE);
			eff = (cap == 0) ? 1 : (cap > DEPTH) ? DEPTH : int'(cap);
			pool_size = eff + $urandom_range(1, 4);
			key_pool.delete();
			for (int k = 0; k < pool_size; k++) begin
				pick = $urandom_range(0, 9);
				if (pick == 0) key_pool.push_back(64'd0);
				else if (pick == 1) key_pool.push_back(KEY_ONES);
				else key_pool.push_back({$urandom, $urandom});
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				beat.operation = $urandom_range(0, 1) ? OP_PUT : OP_GET;
				if ($urandom_range(0, 99) < 85)
					beat.lookup_key = key_pool[$urandom_range(0, pool_size - 1)];
				else
					beat.lookup_key = {$urandom, $urandom};
				pick = $urandom_range(0, 9);
				case (pick)
					0: wv = 32'h8000_0000;
					1: wv = 32'h7FFF_FFFF;
					2: wv = 32'hFFFF_FFFF;
					default: wv = $urandom;
				endcase
				beat.write_value = wv;
				send_item(beat, 1'b0, '0);
			end
		end
		quiet_mode = 1'b0;

		settle();
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("lru_key_value_cache_core verification clean");
		else
			$display("lru_key_value_cache_core verification failed");
		$finish;
	end

endmodule
`default_nettype wire
